### design/lr_pkg.sv
// Shared constants, codes and helpers for the line rasterizer.
`default_nettype none

package lr_pkg;

  // Default coordinate width and fixed widths of the word fields
  localparam int COORD_BITS  = 12;
  localparam int RGBA_BITS   = 32;
  // Entries in the queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // Operation codes of an input word
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // Width of one queue entry: op, start x/y, major, minor, two flags, colour
  function automatic int entry_bits(input int cw);
    return 4 * cw + RGBA_BITS + 3;
  endfunction

endpackage

`default_nettype wire

### design/lr_in_if.sv
// Input channel of the line rasterizer: command words with endpoints and colour.
`default_nettype none

interface lr_in_if #(
  parameter int CW = lr_pkg::COORD_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [CW-1:0]          x_start;
  logic signed [CW-1:0]          y_start;
  logic signed [CW-1:0]          x_end;
  logic signed [CW-1:0]          y_end;
  logic [lr_pkg::RGBA_BITS-1:0]  rgba;

  modport source (
    output valid, op, x_start, y_start, x_end, y_end, rgba,
    input  ready
  );

  modport sink (
    input  valid, op, x_start, y_start, x_end, y_end, rgba,
    output ready
  );
endinterface

`default_nettype wire

### design/lr_out_if.sv
// Output channel of the line rasterizer: one pixel word per handshake.
`default_nettype none

interface lr_out_if #(
  parameter int CW = lr_pkg::COORD_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [CW-1:0]          px;
  logic signed [CW-1:0]          py;
  logic [lr_pkg::RGBA_BITS-1:0]  pixel_rgba;
  logic                          last_pixel;

  modport source (
    output valid, px, py, pixel_rgba, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, px, py, pixel_rgba, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

### design/lr_front.sv
// Front part: accepts command words and turns a load into walker setup values.
`default_nettype none

module lr_front #(
  parameter int CW = lr_pkg::COORD_BITS
) (
  lr_in_if.sink                        in_i,
  input  logic                         q_ready_i,
  output logic                         q_push_o,
  output logic [lr_pkg::entry_bits(CW)-1:0] q_data_o
);
  import lr_pkg::*;

  typedef struct packed {
    logic                 is_load;
    logic [CW-1:0]        start_x;
    logic [CW-1:0]        start_y;
    logic [CW-1:0]        major_len;
    logic [CW-1:0]        minor_len;
    logic                 y_is_major;
    logic                 minor_dir_neg;
    logic [RGBA_BITS-1:0] colour;
  } entry_t;

  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic [CW-1:0]      adx;
  logic [CW-1:0]      ady;
  logic               y_major;
  logic               swap;
  logic signed [CW:0] minor_delta;
  entry_t             entry;

  // Take a word whenever the queue has room
  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid && q_ready_i;

  // Deltas and magnitudes; a magnitude always fits in CW bits
  assign dx  = {in_i.x_end[CW-1], in_i.x_end} - {in_i.x_start[CW-1], in_i.x_start};
  assign dy  = {in_i.y_end[CW-1], in_i.y_end} - {in_i.y_start[CW-1], in_i.y_start};
  assign adx = dx[CW] ? CW'(-dx) : CW'(dx);
  assign ady = dy[CW] ? CW'(-dy) : CW'(dy);

  // Pick the major axis (x on a tie) and the end with the smaller major coordinate
  assign y_major     = ady > adx;
  assign swap        = y_major ? dy[CW] : dx[CW];
  assign minor_delta = y_major ? dx : dy;

  // Classify the word into a queue entry
  always_comb begin
    entry.is_load       = (op_e'(in_i.op) == OP_LOAD);
    entry.start_x       = swap ? in_i.x_end : in_i.x_start;
    entry.start_y       = swap ? in_i.y_end : in_i.y_start;
    entry.major_len     = y_major ? ady : adx;
    entry.minor_len     = y_major ? adx : ady;
    entry.y_is_major    = y_major;
    entry.minor_dir_neg = swap ? (minor_delta > 0) : minor_delta[CW];
    entry.colour        = in_i.rgba;
  end

  assign q_data_o = entry;

endmodule

`default_nettype wire

### design/lr_queue.sv
// Small first-in first-out queue between the front and back parts.
`default_nettype none

module lr_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = lr_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entry storage; no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### design/lr_back.sv
// Back part: Bresenham walker emitting one pixel word per step entry while busy.
`default_nettype none

module lr_back #(
  parameter int CW = lr_pkg::COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  logic [lr_pkg::entry_bits(CW)-1:0] q_data_i,
  output logic                              q_pop_o,
  lr_out_if.source                          out_o
);
  import lr_pkg::*;

  // Error term needs room for twice the sum of error and minor magnitude
  localparam int EW = CW + 3;

  typedef struct packed {
    logic                 is_load;
    logic [CW-1:0]        start_x;
    logic [CW-1:0]        start_y;
    logic [CW-1:0]        major_len;
    logic [CW-1:0]        minor_len;
    logic                 y_is_major;
    logic                 minor_dir_neg;
    logic [RGBA_BITS-1:0] colour;
  } entry_t;

  entry_t               entry;
  logic                 out_free;
  logic                 emit;

  logic                 busy_q;
  logic [CW-1:0]        cur_x_q;
  logic [CW-1:0]        cur_y_q;
  logic signed [EW-1:0] err_q;
  logic [CW-1:0]        major_q;
  logic [CW-1:0]        minor_q;
  logic [CW:0]          left_q;
  logic                 y_major_q;
  logic                 dir_neg_q;
  logic [RGBA_BITS-1:0] colour_q;

  logic                 out_valid_q;
  logic [CW-1:0]        px_q;
  logic [CW-1:0]        py_q;
  logic [RGBA_BITS-1:0] rgba_q;
  logic                 last_q;

  logic                 last;
  logic signed [EW-1:0] err_sum;
  logic signed [EW-1:0] major_ext;
  logic                 minor_step;
  logic signed [EW-1:0] err_next;
  logic [CW-1:0]        major_coord;
  logic [CW-1:0]        minor_coord;
  logic [CW-1:0]        major_next;
  logic [CW-1:0]        minor_next;

  assign entry    = entry_t'(q_data_i);
  assign out_free = !out_valid_q || out_o.ready;

  // Drain loads always, drop steps while idle, stall steps on a full output word
  assign q_pop_o = q_valid_i && (entry.is_load || !busy_q || out_free);
  assign emit    = q_valid_i && !entry.is_load && busy_q && out_free;

  // Error update: add minor, step minor axis when twice the sum reaches major
  assign last       = (left_q <= (CW + 1)'(1));
  assign major_ext  = EW'({3'b000, major_q});
  assign err_sum    = err_q + EW'({3'b000, minor_q});
  assign minor_step = ($signed({err_sum[EW-2:0], 1'b0}) >= major_ext);
  assign err_next   = minor_step ? err_sum - major_ext : err_sum;

  // Coordinate update along the major and minor axes
  assign major_coord = y_major_q ? cur_y_q : cur_x_q;
  assign minor_coord = y_major_q ? cur_x_q : cur_y_q;
  assign major_next  = major_coord + 1'b1;
  assign minor_next  = !minor_step ? minor_coord :
                       (dir_neg_q ? minor_coord - 1'b1 : minor_coord + 1'b1);

  // Walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      err_q     <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      left_q    <= '0;
      y_major_q <= 1'b0;
      dir_neg_q <= 1'b0;
      colour_q  <= '0;
    end else if (q_pop_o && entry.is_load) begin
      busy_q    <= 1'b1;
      cur_x_q   <= entry.start_x;
      cur_y_q   <= entry.start_y;
      err_q     <= '0;
      major_q   <= entry.major_len;
      minor_q   <= entry.minor_len;
      left_q    <= {1'b0, entry.major_len} + 1'b1;
      y_major_q <= entry.y_is_major;
      dir_neg_q <= entry.minor_dir_neg;
      colour_q  <= entry.colour;
    end else if (emit) begin
      if (last) begin
        busy_q <= 1'b0;
        left_q <= '0;
      end else begin
        left_q  <= left_q - 1'b1;
        err_q   <= err_next;
        cur_x_q <= y_major_q ? minor_next : major_next;
        cur_y_q <= y_major_q ? major_next : minor_next;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= cur_x_q;
      py_q   <= cur_y_q;
      rgba_q <= colour_q;
      last_q <= last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.px         = px_q;
  assign out_o.py         = py_q;
  assign out_o.pixel_rgba = rgba_q;
  assign out_o.last_pixel = last_q;

endmodule

`default_nettype wire

### design/line_rasterizer.sv
// Top level of the Bresenham line rasterizer: front, queue and walker.
//
// The rasterizer walks a straight line between two integer endpoints and hands
// out one pixel word for each step word it takes. A load word (op = 0) carries
// both endpoints and a colour and gives no pixel; a load while a line is still
// active drops that line. Each step word (op = 1) gives the next pixel of the
// line, from the end with the smaller coordinate on the major axis to the other,
// both ends included, with last_pixel set on the final one; a step word with no
// line active gives nothing. Sustained rate is one word per clock in and one
// pixel per clock out while the output side takes every pixel: the walker does
// one error add and compare per cycle, a two-entry queue lets the input side run
// ahead of the walker, and the output word register takes a new pixel as its
// held one is taken, though the walker stalls while a pixel waits to be taken.
`default_nettype none

module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lr_in_if.sink     in_i,
  lr_out_if.source  out_o
);
  import lr_pkg::*;

  localparam int ENTRY_W = entry_bits(COORD_BITS);

  logic               push;
  logic               q_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] head_data;

  // Accept and classify command words
  lr_front #(
    .CW (COORD_BITS)
  ) u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .q_push_o  (push),
    .q_data_o  (push_data)
  );

  // Decouple the front from the walker
  lr_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_data)
  );

  // Walk the line and emit pixels
  lr_back #(
    .CW (COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (head_data),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

### bench/line_rasterizer_test.sv
// Self-checking testbench for the line rasterizer: directed and random line walks.
module line_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lr_pkg::*;

  localparam int CW          = lr_pkg::COORD_BITS;
  localparam int CMIN        = -(1 << (CW - 1));
  localparam int CMAX        = (1 << (CW - 1)) - 1;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_WORDS = 300;
  localparam int MAX_REPORTS = 40;

  // One command word on the input channel
  typedef struct {
    op_e                   op;
    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  ys;
    logic signed [CW-1:0]  xe;
    logic signed [CW-1:0]  ye;
    logic [RGBA_BITS-1:0]  rgba;
  } word_t;

  // One pixel word on the output channel
  typedef struct {
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic [RGBA_BITS-1:0]  rgba;
    logic                  last;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  lr_in_if  #(.CW(CW)) in_if ();
  lr_out_if #(.CW(CW)) out_if ();

  line_rasterizer #(.COORD_BITS(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Stimulus and scoreboard
  word_t  words_to_send[$];
  pixel_t pending_pixels[$];
  int     words_queued   = 0;
  int     words_accepted = 0;
  int     errors         = 0;
  int     reports_left   = MAX_REPORTS;
  int     quiet_cycles   = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     holds_asked    = 0;
  int     holds_granted  = 0;
  int     hold_left      = 0;
  logic   word_taken     = 1'b0;

  // Walker model state
  bit               walk_busy;
  logic [CW-1:0]    walk_x;
  logic [CW-1:0]    walk_y;
  int               walk_err;
  int               walk_major;
  int               walk_minor;
  int               walk_left;
  bit               walk_y_major;
  bit               walk_minor_neg;
  logic [RGBA_BITS-1:0] walk_colour;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Arm the walker with a new line, or emit the next pixel of the current one
  task automatic walk_word(input word_t w);
    int  xs, ys, xe, ye, dx, dy, adx, ady, minor_delta, e;
    bit  swap, minor_step;
    xs = w.xs;
    ys = w.ys;
    xe = w.xe;
    ye = w.ye;
    case (w.op)
      OP_LOAD: begin
        dx  = xe - xs;
        dy  = ye - ys;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        walk_y_major = ady > adx;
        swap = walk_y_major ? (dy < 0) : (dx < 0);
        if (swap) begin
          walk_x = CW'(xe);
          walk_y = CW'(ye);
          minor_delta = walk_y_major ? -dx : -dy;
        end else begin
          walk_x = CW'(xs);
          walk_y = CW'(ys);
          minor_delta = walk_y_major ? dx : dy;
        end
        walk_minor_neg = minor_delta < 0;
        walk_major  = walk_y_major ? ady : adx;
        walk_minor  = walk_y_major ? adx : ady;
        walk_left   = walk_major + 1;
        walk_err    = 0;
        walk_colour = w.rgba;
        walk_busy   = 1'b1;
      end
      OP_STEP: begin
        if (walk_busy) begin
          pending_pixels.push_back('{walk_x, walk_y, walk_colour, walk_left <= 1});
          if (walk_left <= 1) begin
            walk_left = 0;
            walk_busy = 1'b0;
          end else begin
            walk_left--;
            e = walk_err + walk_minor;
            minor_step = 2 * e >= walk_major;
            if (minor_step) e -= walk_major;
            walk_err = e;
            if (walk_y_major) begin
              walk_y = walk_y + 1'b1;
              if (minor_step) walk_x = walk_minor_neg ? walk_x - 1'b1 : walk_x + 1'b1;
            end else begin
              walk_x = walk_x + 1'b1;
              if (minor_step) walk_y = walk_minor_neg ? walk_y - 1'b1 : walk_y + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [CW-1:0] to_coord(input int v);
    if (v < CMIN) v = CMIN;
    if (v > CMAX) v = CMAX;
    return CW'(v);
  endfunction

  task automatic add_load(input int xs, input int ys, input int xe, input int ye,
                          input logic [RGBA_BITS-1:0] rgba);
    words_to_send.push_back('{OP_LOAD, to_coord(xs), to_coord(ys), to_coord(xe),
                              to_coord(ye), rgba});
    words_queued++;
  endtask

  // Step words carry random junk in the unused fields
  task automatic add_steps(input int n);
    repeat (n) begin
      words_to_send.push_back('{OP_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                                CW'($urandom), $urandom});
      words_queued++;
    end
  endtask

  // Load a random line within reach of a random start; return its pixel count
  task automatic add_random_line(input int reach, output int n);
    int xs, ys, xe, ye, adx, ady;
    xs = to_coord(int'($urandom_range(CMAX - CMIN)) + CMIN);
    ys = to_coord(int'($urandom_range(CMAX - CMIN)) + CMIN);
    xe = to_coord(xs + int'($urandom_range(2 * reach)) - reach);
    ye = to_coord(ys + int'($urandom_range(2 * reach)) - reach);
    add_load(xs, ys, xe, ye, $urandom);
    adx = (xe > xs) ? xe - xs : xs - xe;
    ady = (ye > ys) ? ye - ys : ys - ye;
    n = ((adx > ady) ? adx : ady) + 1;
  endtask

  // Mostly whole lines; some cut short, some overrun, plus stray words
  task automatic fill_phase(input int budget);
    int count, kind, n, steps;
    count = 0;
    while (count < budget) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        add_random_line(($urandom_range(29) == 0) ? 200 : 12, n);
        case ($urandom_range(9))
          0:       steps = $urandom_range(n);
          1:       steps = n + $urandom_range(1, 3);
          default: steps = n;
        endcase
        add_steps(steps);
        count += 1 + ((steps < n) ? steps : n);
      end else if (kind < 90) begin
        add_steps($urandom_range(1, 3));
      end else begin
        add_random_line(2047, n);
        count++;
      end
    end
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || pending_pixels.size() != 0)
      @(posedge clk_i);
  endtask

  // Sequence the run: reset, directed lines, then random phases
  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_LOAD;
    in_if.x_start    = '0;
    in_if.y_start    = '0;
    in_if.x_end      = '0;
    in_if.y_end      = '0;
    in_if.rgba       = '0;
    out_if.ready     = 1'b0;
    walk_busy        = 1'b0;
    walk_x           = '0;
    walk_y           = '0;
    walk_err         = 0;
    walk_major       = 0;
    walk_minor       = 0;
    walk_left        = 0;
    walk_y_major     = 1'b0;
    walk_minor_neg   = 1'b0;
    walk_colour      = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: step with no line, zero length, extremes, diagonal, both minor signs
    add_steps(1);
    add_load(5, -7, 5, -7, 32'h1122_3344);
    add_steps(2);
    add_load(CMIN, CMIN, CMAX, CMAX, 32'hFFFF_FFFF);
    add_steps(1);
    add_load(CMAX, CMAX, CMAX - 3, CMAX - 4, 32'h0000_0000);
    add_steps(5);
    add_load(3, 3, 0, 0, 32'h8000_0001);
    add_steps(4);
    add_load(CMIN, 10, CMIN + 5, 8, 32'h5A5A_A5A5);
    add_steps(6);
    fill_phase(PHASE_WORDS);
    wait_drained();

    // Sender idles
    send_idle_pct = 58;
    fill_phase(PHASE_WORDS);
    wait_drained();

    // Receiver stalls, starting with a long hold-off while words keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    holds_asked++;
    fill_phase(PHASE_WORDS);
    wait_drained();

    // Both sides idle
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    fill_phase(PHASE_WORDS);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Offer command words; advance only once the current word was taken
  always @(negedge clk_i) begin : drive_words
    word_t w;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || word_taken) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = words_to_send.pop_front();
        in_if.valid   <= 1'b1;
        in_if.op      <= w.op;
        in_if.x_start <= w.xs;
        in_if.y_start <= w.ys;
        in_if.x_end   <= w.xe;
        in_if.y_end   <= w.ye;
        in_if.rgba    <= w.rgba;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Drive ready: long hold-off on request, random stalls otherwise
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= HOLD_CYCLES;
      out_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each pixel word against the model and feed accepted words to it
  always @(posedge clk_i) begin : watch_ports
    pixel_t got;
    pixel_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.px, out_if.py, out_if.pixel_rgba, out_if.last_pixel};
        if (pending_pixels.size() == 0) begin
          errors++;
          if (reports_left > 0) begin
            reports_left--;
            $display("%0t: unexpected pixel x=%0d y=%0d rgba=%h last=%b", $time,
                     got.px, got.py, got.rgba, got.last);
          end
        end else begin
          want = pending_pixels.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.rgba !== want.rgba ||
              got.last !== want.last) begin
            errors++;
            if (reports_left > 0) begin
              reports_left--;
              $display("%0t: pixel mismatch expected x=%0d y=%0d rgba=%h last=%b",
                       $time, want.px, want.py, want.rgba, want.last,
                       " actual x=%0d y=%0d rgba=%h last=%b",
                       got.px, got.py, got.rgba, got.last);
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        walk_word('{op_e'(in_if.op), in_if.x_start, in_if.y_start, in_if.x_end,
                    in_if.y_end, in_if.rgba});
        words_accepted++;
      end
      // Watchdog: count cycles with no word moving on either channel
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
    word_taken <= rst_ni && in_if.valid && in_if.ready;
  end

endmodule
